@@ rtl/core/conv2d_valid_byte_wrap_macros.svh @@
// Assertion macros shared by the convolution block.
`ifndef CONV2D_VALID_BYTE_WRAP_MACROS_SVH
`define CONV2D_VALID_BYTE_WRAP_MACROS_SVH
`ifndef SYNTH
`define CV2_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cv2 assertion failed");
`define CV2_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("cv2 forbidden condition seen");
`else
`define CV2_ASSERT(lbl, clk, rstn, prop)
`define CV2_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ rtl/core/cv2_pkg.sv @@
// Package with constants and types of the convolution block.
`timescale 1ns / 1ps
`default_nettype none
package cv2_pkg;

  localparam int MAX_KERNEL = 5;
  localparam int MAX_LINE = 1024;
  localparam int NTAP = MAX_KERNEL * MAX_KERNEL;
  localparam int TAP_W = $clog2(NTAP);
  localparam int NLINE = MAX_KERNEL - 1;
  localparam int COL_W = $clog2(MAX_LINE);
  localparam int K_W = 3;
  localparam int LW_W = 11;
  localparam int FH_W = 13;
  localparam int ROW_W = 13;
  localparam int OCOL_W = 10;
  localparam int OROW_W = 12;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int COEFF_PER_WORD = 8;
  localparam int NSTAGE = 5;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
  localparam int OCC_W = $clog2(FIFO_DEPTH + NSTAGE + 1);

  localparam logic [K_W-1:0] KERNEL_RST = 3'd3;
  localparam logic [LW_W-1:0] IN_W_RST = 11'd1024;
  localparam logic [LW_W-1:0] OUT_W_RST = 11'd1022;
  localparam logic [FH_W-1:0] OUT_H_RST = 13'd1022;
  localparam logic [FH_W-1:0] MAX_OUT_H = 13'd4096;

  typedef logic [7:0] pix_t;
  typedef pix_t [NTAP-1:0] coef_map_t;
  typedef pix_t [NLINE-1:0] line_word_t;

  typedef struct packed {
    logic [K_W-1:0]  k;
    logic [LW_W-1:0] w;
    logic [LW_W-1:0] ow;
    logic [FH_W-1:0] oh;
  } cfg_eff_t;

  typedef struct packed {
    pix_t              pixel;
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic              last;
  } out_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_SIZE = 3'd0,
    CFG_IN_WIDTH    = 3'd1,
    CFG_OUT_WIDTH   = 3'd2,
    CFG_OUT_HEIGHT  = 3'd3,
    CFG_COEFF_0     = 3'd4,
    CFG_COEFF_1     = 3'd5,
    CFG_COEFF_2     = 3'd6,
    CFG_COEFF_3     = 3'd7
  } cfg_idx_e;

endpackage
`default_nettype wire

@@ rtl/core/cv2_cfg.sv @@
// Configuration registers, clamped frame geometry and the kernel coefficient map.
`timescale 1ns / 1ps
`default_nettype none
module cv2_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cv2_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cv2_pkg::CFG_W-1:0]      cfg_data_i,
  output cv2_pkg::cfg_eff_t              cfg_o,
  output cv2_pkg::coef_map_t             cmap_o
);
  import cv2_pkg::*;

  logic [K_W-1:0]  k_q;
  logic [LW_W-1:0] w_q;
  logic [LW_W-1:0] ow_q;
  logic [FH_W-1:0] oh_q;
  pix_t [NTAP-1:0] coeff_q;

  logic [K_W-1:0]  k_eff;
  logic [LW_W-1:0] w_eff;
  logic [LW_W-1:0] ow_max;
  logic [K_W-1:0]  off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= KERNEL_RST;
      w_q     <= IN_W_RST;
      ow_q    <= OUT_W_RST;
      oh_q    <= OUT_H_RST;
      coeff_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KERNEL_SIZE: k_q <= cfg_data_i[K_W-1:0];
        CFG_IN_WIDTH:    w_q <= cfg_data_i[LW_W-1:0];
        CFG_OUT_WIDTH:   ow_q <= cfg_data_i[LW_W-1:0];
        CFG_OUT_HEIGHT:  oh_q <= cfg_data_i[FH_W-1:0];
        CFG_COEFF_0: begin
          for (int i = 0; i < COEFF_PER_WORD; i++) coeff_q[i] <= cfg_data_i[8*i +: 8];
        end
        CFG_COEFF_1: begin
          for (int i = 0; i < COEFF_PER_WORD; i++) begin
            coeff_q[COEFF_PER_WORD + i] <= cfg_data_i[8*i +: 8];
          end
        end
        CFG_COEFF_2: begin
          for (int i = 0; i < COEFF_PER_WORD; i++) begin
            coeff_q[2*COEFF_PER_WORD + i] <= cfg_data_i[8*i +: 8];
          end
        end
        CFG_COEFF_3: coeff_q[3*COEFF_PER_WORD] <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (k_q == '0) begin
      k_eff = K_W'(1);
    end else if (k_q > K_W'(MAX_KERNEL)) begin
      k_eff = K_W'(MAX_KERNEL);
    end else begin
      k_eff = k_q;
    end
    if (w_q == '0) begin
      w_eff = LW_W'(1);
    end else if (w_q > LW_W'(MAX_LINE)) begin
      w_eff = LW_W'(MAX_LINE);
    end else begin
      w_eff = w_q;
    end
    ow_max = (w_eff >= LW_W'(k_eff)) ? (w_eff - LW_W'(k_eff) + LW_W'(1)) : '0;
    cfg_o.k  = k_eff;
    cfg_o.w  = w_eff;
    cfg_o.ow = (ow_q < ow_max) ? ow_q : ow_max;
    cfg_o.oh = (oh_q > MAX_OUT_H) ? MAX_OUT_H : oh_q;
  end

  // The k by k kernel sits in the bottom right corner of the full window.
  always_comb begin
    logic [K_W-1:0]   dy;
    logic [K_W-1:0]   dx;
    logic [TAP_W-1:0] idx;
    dy = '0;
    dx = '0;
    idx = '0;
    off = K_W'(MAX_KERNEL) - k_eff;
    for (int y = 0; y < MAX_KERNEL; y++) begin
      for (int x = 0; x < MAX_KERNEL; x++) begin
        dy = K_W'(y) - off;
        dx = K_W'(x) - off;
        idx = TAP_W'(dy) * TAP_W'(k_eff) + TAP_W'(dx);
        if (K_W'(y) >= off && K_W'(x) >= off) begin
          cmap_o[y*MAX_KERNEL + x] = coeff_q[idx];
        end else begin
          cmap_o[y*MAX_KERNEL + x] = '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/cv2_lmem.sv @@
// Line store memory with post-reset clearing and same-column write forwarding.
`timescale 1ns / 1ps
`default_nettype none
`include "conv2d_valid_byte_wrap_macros.svh"
module cv2_lmem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [cv2_pkg::COL_W-1:0]  rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [cv2_pkg::COL_W-1:0]  wr_addr_i,
  input  cv2_pkg::line_word_t        wr_data_i,
  output cv2_pkg::line_word_t        rd_data_o,
  output logic                       busy_o
);
  import cv2_pkg::*;

  line_word_t mem [MAX_LINE];
  line_word_t rdata_q;
  line_word_t fwd_data_q;
  logic       fwd_q;
  logic       clear_q;
  logic [COL_W-1:0] clr_addr_q;

  logic             mem_we;
  logic [COL_W-1:0] mem_waddr;
  line_word_t       mem_wdata;

  assign mem_we    = clear_q | wr_en_i;
  assign mem_waddr = clear_q ? clr_addr_q : wr_addr_i;
  assign mem_wdata = clear_q ? line_word_t'('0) : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
      fwd_q      <= 1'b0;
    end else begin
      if (clear_q) begin
        clr_addr_q <= clr_addr_q + COL_W'(1);
        if (clr_addr_q == COL_W'(MAX_LINE - 1)) begin
          clear_q <= 1'b0;
        end
      end
      if (rd_en_i) begin
        fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;
  assign busy_o    = clear_q;

  `CV2_ASSERT(a_no_read_in_clear, clk_i, rst_ni, rd_en_i |-> !clear_q)
  `CV2_ASSERT(a_forward, clk_i, rst_ni, (rd_en_i && wr_en_i && rd_addr_i == wr_addr_i) |=> (rd_data_o == $past(wr_data_i)))
  `CV2_ASSERT(a_clear_ends, clk_i, rst_ni, (clear_q && clr_addr_q == COL_W'(MAX_LINE - 1)) |=> !clear_q)

endmodule
`default_nettype wire

@@ rtl/core/cv2_mac.sv @@
// Window registers, per-tap byte products and the wrapping sum tree.
`timescale 1ns / 1ps
`default_nettype none
module cv2_mac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  cv2_pkg::pix_t        pix_i,
  input  cv2_pkg::line_word_t  lines_i,
  input  cv2_pkg::coef_map_t   cmap_i,
  output cv2_pkg::pix_t        sum_o
);
  import cv2_pkg::*;

  typedef pix_t [MAX_KERNEL-1:0][MAX_KERNEL-1:0] window_t;

  window_t              win_q;
  pix_t [NTAP-1:0]      prod_d, prod_q;
  pix_t [MAX_KERNEL-1:0] psum_d, psum_q;
  pix_t                 sum_d, sum_q;

  // The top window row is the oldest line; the new pixel enters bottom right.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      for (int y = 0; y < MAX_KERNEL; y++) begin
        for (int x = 0; x < MAX_KERNEL - 1; x++) win_q[y][x] <= win_q[y][x+1];
      end
      for (int y = 0; y < NLINE; y++) win_q[y][MAX_KERNEL-1] <= lines_i[NLINE-1-y];
      win_q[MAX_KERNEL-1][MAX_KERNEL-1] <= pix_i;
    end
  end

  always_comb begin
    for (int y = 0; y < MAX_KERNEL; y++) begin
      for (int x = 0; x < MAX_KERNEL; x++) begin
        prod_d[y*MAX_KERNEL + x] = 8'(win_q[y][x] * cmap_i[y*MAX_KERNEL + x]);
      end
    end
  end

  always_comb begin
    for (int y = 0; y < MAX_KERNEL; y++) begin
      psum_d[y] = '0;
      for (int x = 0; x < MAX_KERNEL; x++) psum_d[y] = psum_d[y] + prod_q[y*MAX_KERNEL + x];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int y = 0; y < MAX_KERNEL; y++) sum_d = sum_d + psum_q[y];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    psum_q <= psum_d;
    sum_q  <= sum_d;
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

@@ rtl/core/cv2_ofifo.sv @@
// Output queue that decouples the free-running pipeline from the result channel.
`timescale 1ns / 1ps
`default_nettype none
module cv2_ofifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  cv2_pkg::out_word_t            data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output cv2_pkg::out_word_t            data_o,
  output logic [cv2_pkg::FIFO_CW-1:0]   count_o
);
  import cv2_pkg::*;

  out_word_t          buf_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + FIFO_CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - FIFO_CW'(1);
      end
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule
`default_nettype wire

@@ rtl/core/conv2d_valid_byte_wrap.sv @@
// Top level of the 2-D valid-window convolution with a wrapping byte sum.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------------
//   config   | cfg_we_i                  | cfg_idx_i, cfg_data_i
//   input    | in_valid_i / in_ready_o   | pixel_in_i, frame_start_i
//   output   | out_valid_o / out_ready_i | pixel_out_o, out_col_o, out_row_o,
//            |                           | frame_last_o
//
// One input word is taken per cycle while in_ready_o is high; the line store is read and
// written once per word. Results pass the window, product, row-sum and sum registers.
// After reset the line store clears all 1024 columns, and in_ready_o stays low meanwhile.
// An eight-word output queue absorbs stalls; after the clear, input waits only if it could overflow.
`timescale 1ns / 1ps
`default_nettype none
`include "conv2d_valid_byte_wrap_macros.svh"
module conv2d_valid_byte_wrap (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cv2_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cv2_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cv2_pkg::pix_t                   pixel_in_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output cv2_pkg::pix_t                   pixel_out_o,
  output logic [cv2_pkg::OCOL_W-1:0]      out_col_o,
  output logic [cv2_pkg::OROW_W-1:0]      out_row_o,
  output logic                            frame_last_o
);
  import cv2_pkg::*;

  typedef struct packed {
    logic              emit;
    logic [OCOL_W-1:0] oc;
    logic [OROW_W-1:0] orow;
    logic              last;
  } meta_t;

  cfg_eff_t   cfg;
  coef_map_t  cmap;
  line_word_t rd_lines;
  line_word_t wr_lines;
  pix_t       sum;
  logic       busy;

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] c0;
  logic [ROW_W-1:0] r0;
  logic [K_W-1:0]   km1;
  logic [COL_W-1:0] oc;
  logic [ROW_W-1:0] orow_full;
  meta_t            meta_d;

  logic [NSTAGE-1:0] s_valid_q;
  meta_t             meta_q [NSTAGE];
  logic [COL_W-1:0]  s1_col_q;
  pix_t              s1_pix_q;

  logic               accept;
  logic               push;
  logic               pop;
  out_word_t          push_word;
  out_word_t          head_word;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic [OCC_W-1:0]   occ;

  cv2_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .cmap_o     (cmap)
  );

  assign c0        = frame_start_i ? '0 : col_q;
  assign r0        = frame_start_i ? '0 : row_q;
  assign km1       = cfg.k - K_W'(1);
  assign oc        = c0 - COL_W'(km1);
  assign orow_full = r0 - ROW_W'(km1);

  always_comb begin
    meta_d.emit = (c0 >= COL_W'(km1)) && (r0 >= ROW_W'(km1)) &&
                  (LW_W'(oc) < cfg.ow) && (orow_full < cfg.oh);
    meta_d.oc   = oc;
    meta_d.orow = orow_full[OROW_W-1:0];
    meta_d.last = (LW_W'(oc) == cfg.ow - LW_W'(1)) && (orow_full == cfg.oh - FH_W'(1));
  end

  always_comb begin
    occ = OCC_W'(fifo_cnt);
    for (int s = 0; s < NSTAGE; s++) occ = occ + OCC_W'(s_valid_q[s] & meta_q[s].emit);
  end

  assign in_ready_o = !busy && (occ < OCC_W'(FIFO_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      s_valid_q <= '0;
    end else begin
      s_valid_q <= {s_valid_q[NSTAGE-2:0], accept};
      if (accept) begin
        if (LW_W'(c0) + LW_W'(1) >= cfg.w) begin
          col_q <= '0;
          row_q <= (r0 == '1) ? r0 : r0 + ROW_W'(1);
        end else begin
          col_q <= c0 + COL_W'(1);
          row_q <= r0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q[0] <= meta_d;
    for (int s = 1; s < NSTAGE; s++) meta_q[s] <= meta_q[s-1];
    if (accept) begin
      s1_col_q <= c0;
      s1_pix_q <= pixel_in_i;
    end
  end

  assign wr_lines = line_word_t'({rd_lines[NLINE-2:0], s1_pix_q});

  cv2_lmem u_lmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (c0),
    .wr_en_i   (s_valid_q[0]),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_lines),
    .rd_data_o (rd_lines),
    .busy_o    (busy)
  );

  cv2_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s_valid_q[0]),
    .pix_i   (s1_pix_q),
    .lines_i (rd_lines),
    .cmap_i  (cmap),
    .sum_o   (sum)
  );

  assign push = s_valid_q[NSTAGE-1] && meta_q[NSTAGE-1].emit;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    push_word.pixel = sum;
    push_word.col   = meta_q[NSTAGE-1].oc;
    push_word.row   = meta_q[NSTAGE-1].orow;
    push_word.last  = meta_q[NSTAGE-1].last;
  end

  cv2_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_word),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (head_word),
    .count_o (fifo_cnt)
  );

  assign pixel_out_o  = head_word.pixel;
  assign out_col_o    = head_word.col;
  assign out_row_o    = head_word.row;
  assign frame_last_o = head_word.last;

  `CV2_NEVER(a_occ_bound, clk_i, rst_ni, occ > OCC_W'(FIFO_DEPTH))
  `CV2_ASSERT(a_accept_enters, clk_i, rst_ni, accept |=> s_valid_q[0])
  `CV2_NEVER(a_push_when_full, clk_i, rst_ni, push && fifo_cnt == FIFO_CW'(FIFO_DEPTH))

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the 2-D valid-window convolution with a wrapping byte sum.
module tb_top;
  import cv2_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS = 24;
  localparam int ROW_SAT = 2 ** ROW_W - 1;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_HIT, ROW_MISS} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] data;
    pix_t             pix;
    logic             start;
    out_word_t        want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  pix_t pixel_in_i;
  logic frame_start_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pix_t pixel_out_o;
  logic [OCOL_W-1:0] out_col_o;
  logic [OROW_W-1:0] out_row_o;
  logic frame_last_o;

  logic [K_W-1:0] kern_reg;
  logic [LW_W-1:0] in_w_reg;
  logic [LW_W-1:0] out_w_reg;
  logic [FH_W-1:0] out_h_reg;
  pix_t coef [NTAP];
  pix_t rows_mem [MAX_KERNEL][MAX_LINE];
  pix_t win [MAX_KERNEL][MAX_KERNEL];
  int unsigned col_pos;
  int unsigned row_pos;

  out_word_t pending_words [$];
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  // Rows typed as hit or miss carry their own expectation; pixel rows use the predictor.
  dir_row_t directed_rows [31] = '{
    '{ROW_MISS, CFG_KERNEL_SIZE, 64'd0,    8'h12, 1'b1, '0},
    '{ROW_CFG,  CFG_KERNEL_SIZE, 64'd0,    8'h00, 1'b0, '0},
    '{ROW_CFG,  CFG_IN_WIDTH,    64'd2,    8'h00, 1'b0, '0},
    '{ROW_CFG,  CFG_OUT_WIDTH,   64'd2047, 8'h00, 1'b0, '0},
    '{ROW_CFG,  CFG_OUT_HEIGHT,  64'd2,    8'h00, 1'b0, '0},
    '{ROW_CFG,  CFG_COEFF_0,     64'h01,   8'h00, 1'b0, '0},
    '{ROW_HIT,  CFG_KERNEL_SIZE, 64'd0,    8'h00, 1'b1, '{8'h00, 10'd0, 12'd0, 1'b0}},
    '{ROW_HIT,  CFG_KERNEL_SIZE, 64'd0,    8'hFF, 1'b0, '{8'hFF, 10'd1, 12'd0, 1'b0}},
    '{ROW_HIT,  CFG_KERNEL_SIZE, 64'd0,    8'h80, 1'b0, '{8'h80, 10'd0, 12'd1, 1'b0}},
    '{ROW_HIT,  CFG_KERNEL_SIZE, 64'd0,    8'h7F, 1'b0, '{8'h7F, 10'd1, 12'd1, 1'b1}},
    '{ROW_MISS, CFG_KERNEL_SIZE, 64'd0,    8'h33, 1'b0, '0},
    '{ROW_CFG,  CFG_COEFF_0,     64'hFF,   8'h00, 1'b0, '0},
    '{ROW_HIT,  CFG_KERNEL_SIZE, 64'd0,    8'hFF, 1'b1, '{8'h01, 10'd0, 12'd0, 1'b0}},
    '{ROW_HIT,  CFG_KERNEL_SIZE, 64'd0,    8'h01, 1'b0, '{8'hFF, 10'd1, 12'd0, 1'b0}},
    '{ROW_CFG,  CFG_KERNEL_SIZE, 64'd2,    8'h00, 1'b0, '0},
    '{ROW_CFG,  CFG_OUT_HEIGHT,  64'd1,    8'h00, 1'b0, '0},
    '{ROW_CFG,  CFG_COEFF_0,     64'h04030201, 8'h00, 1'b0, '0},
    '{ROW_MISS, CFG_KERNEL_SIZE, 64'd0,    8'h01, 1'b1, '0},
    '{ROW_MISS, CFG_KERNEL_SIZE, 64'd0,    8'h02, 1'b0, '0},
    '{ROW_MISS, CFG_KERNEL_SIZE, 64'd0,    8'h03, 1'b0, '0},
    '{ROW_HIT,  CFG_KERNEL_SIZE, 64'd0,    8'h04, 1'b0, '{8'h1E, 10'd0, 12'd0, 1'b1}},
    '{ROW_CFG,  CFG_KERNEL_SIZE, 64'd1,    8'h00, 1'b0, '0},
    '{ROW_CFG,  CFG_OUT_WIDTH,   64'd0,    8'h00, 1'b0, '0},
    '{ROW_MISS, CFG_KERNEL_SIZE, 64'd0,    8'hAA, 1'b1, '0},
    '{ROW_CFG,  CFG_OUT_WIDTH,   64'd1,    8'h00, 1'b0, '0},
    '{ROW_CFG,  CFG_OUT_HEIGHT,  64'd0,    8'h00, 1'b0, '0},
    '{ROW_MISS, CFG_KERNEL_SIZE, 64'd0,    8'h55, 1'b1, '0},
    '{ROW_CFG,  CFG_OUT_HEIGHT,  64'd1,    8'h00, 1'b0, '0},
    '{ROW_HIT,  CFG_KERNEL_SIZE, 64'd0,    8'h55, 1'b1, '{8'h55, 10'd0, 12'd0, 1'b1}},
    '{ROW_MISS, CFG_KERNEL_SIZE, 64'd0,    8'h66, 1'b0, '0},
    '{ROW_MISS, CFG_KERNEL_SIZE, 64'd0,    8'h77, 1'b0, '0}
  };

  conv2d_valid_byte_wrap dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_in_i    (pixel_in_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_out_o   (pixel_out_o),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .frame_last_o  (frame_last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void apply_reg_write(input cfg_idx_e idx, input logic [CFG_W-1:0] d);
    int base;
    base = (int'(idx) - int'(CFG_COEFF_0)) * COEFF_PER_WORD;
    case (idx)
      CFG_KERNEL_SIZE: kern_reg = d[K_W-1:0];
      CFG_IN_WIDTH:    in_w_reg = d[LW_W-1:0];
      CFG_OUT_WIDTH:   out_w_reg = d[LW_W-1:0];
      CFG_OUT_HEIGHT:  out_h_reg = d[FH_W-1:0];
      CFG_COEFF_3:     coef[NTAP-1] = d[7:0];
      default: begin
        for (int i = 0; i < COEFF_PER_WORD; i++) coef[base + i] = d[8*i +: 8];
      end
    endcase
  endfunction

  function automatic bit conv_predict(input pix_t p, input logic s, output out_word_t o);
    int unsigned k, w, ow, oh, c, r, off;
    pix_t acc;
    bit hit;
    k = kern_reg;
    if (k < 1) k = 1;
    if (k > MAX_KERNEL) k = MAX_KERNEL;
    w = in_w_reg;
    if (w < 1) w = 1;
    if (w > MAX_LINE) w = MAX_LINE;
    ow = (w >= k) ? w - k + 1 : 0;
    if (out_w_reg < ow) ow = out_w_reg;
    oh = out_h_reg;
    if (oh > MAX_OUT_H) oh = MAX_OUT_H;
    if (s) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = (col_pos >= MAX_LINE) ? MAX_LINE - 1 : col_pos;
    r = row_pos;
    // The window slides left by one; the line stores and the new pixel fill the right column.
    for (int i = 0; i < MAX_KERNEL; i++) begin
      for (int j = 0; j < MAX_KERNEL - 1; j++) win[i][j] = win[i][j+1];
    end
    for (int i = 0; i < NLINE; i++) win[i][MAX_KERNEL-1] = rows_mem[NLINE-1-i][c];
    win[NLINE][MAX_KERNEL-1] = p;
    for (int i = NLINE; i > 0; i--) rows_mem[i][c] = rows_mem[i-1][c];
    rows_mem[0][c] = p;
    hit = 1'b0;
    o = '0;
    if (c >= k - 1 && r >= k - 1 && c - (k - 1) < ow && r - (k - 1) < oh) begin
      off = MAX_KERNEL - k;
      acc = '0;
      for (int i = 0; i < k; i++) begin
        for (int j = 0; j < k; j++) acc = acc + coef[i*k+j] * win[off+i][off+j];
      end
      o.pixel = acc;
      o.col = OCOL_W'(c - (k - 1));
      o.row = OROW_W'(r - (k - 1));
      o.last = (c - (k - 1) == ow - 1) && (r - (k - 1) == oh - 1);
      hit = 1'b1;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      if (row_pos < ROW_SAT) row_pos++;
    end else begin
      col_pos = c + 1;
    end
    return hit;
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg_write(idx, d);
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input pix_t p, input logic s, input row_kind_e kind,
                            input out_word_t typed);
    out_word_t predicted;
    bit hit;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= p;
    frame_start_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    hit = conv_predict(p, s, predicted);
    if (kind == ROW_HIT) pending_words.push_back(typed);
    else if (kind == ROW_PIX && hit) pending_words.push_back(predicted);
    @(negedge clk_i);
  endtask

  task automatic pause_until_drained(input int extra);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_words.size() != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk_i) begin : check_out
    out_word_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{pixel_out_o, out_col_o, out_row_o, frame_last_o};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: pixel %h col %0d row %0d last %b",
                   got.pixel, got.col, got.row, got.last);
      end else begin
        want = pending_words.pop_front();
        if (got.pixel !== want.pixel || got.col !== want.col ||
            got.row !== want.row || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pixel %h col %0d row %0d last %b, %s",
                     want.pixel, want.col, want.row, want.last,
                     $sformatf("got pixel %h col %0d row %0d last %b",
                               got.pixel, got.col, got.row, got.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int k_eff, w_eff, oh_eff, rows, frame_len, sent;
    logic st;
    logic [CFG_W-1:0] v;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    pixel_in_i = '0;
    frame_start_i = 1'b0;
    kern_reg = KERNEL_RST;
    in_w_reg = IN_W_RST;
    out_w_reg = OUT_W_RST;
    out_h_reg = OUT_H_RST;
    for (int i = 0; i < NTAP; i++) coef[i] = '0;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      for (int j = 0; j < MAX_LINE; j++) rows_mem[i][j] = '0;
      for (int j = 0; j < MAX_KERNEL; j++) win[i][j] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_CFG) begin
        pause_until_drained(DRAIN_CYCLES);
        write_reg(directed_rows[n].idx, directed_rows[n].data);
      end else begin
        send_pixel(directed_rows[n].pix, directed_rows[n].start, directed_rows[n].kind,
                   directed_rows[n].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pause_until_drained(DRAIN_CYCLES);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      write_reg(CFG_KERNEL_SIZE, $urandom_range(0, 7));
      k_eff = (kern_reg == 0) ? 1 : (kern_reg > MAX_KERNEL) ? MAX_KERNEL : kern_reg;
      case ($urandom_range(0, 9))
        0: v = 0;
        1: v = $urandom_range(13, 40);
        default: v = $urandom_range(k_eff, k_eff + 8);
      endcase
      write_reg(CFG_IN_WIDTH, v);
      w_eff = (v == 0) ? 1 : int'(v);
      case ($urandom_range(0, 5))
        0: v = 2047;
        1: v = $urandom_range(0, w_eff + 1);
        default: v = (w_eff >= k_eff) ? w_eff - k_eff + 1 : 1;
      endcase
      write_reg(CFG_OUT_WIDTH, v);
      case ($urandom_range(0, 7))
        0: v = 0;
        1: v = 8191;
        default: v = $urandom_range(1, 5);
      endcase
      write_reg(CFG_OUT_HEIGHT, v);
      oh_eff = (v > 6) ? 6 : int'(v);
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = '1;
          default: v = {$urandom, $urandom};
        endcase
        write_reg(cfg_idx_e'(int'(CFG_COEFF_0) + i), v);
      end
      // Frames mostly start cleanly; some carry on from the previous phase or restart early.
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        rows = oh_eff + k_eff - 1 + $urandom_range(0, 1);
        frame_len = rows * w_eff + $urandom_range(0, 2);
        for (int i = 0; i < frame_len && sent < PHASE_ITEMS; i++) begin
          st = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 59) == 0);
          if (ph % 3 == 1 && sent == PHASE_ITEMS / 2) pause_until_drained(0);
          send_pixel(rand_pixel(), st, ROW_PIX, '0);
          sent++;
        end
      end
    end

    // One full row at the clamped input width runs the column counter to its top.
    pause_until_drained(DRAIN_CYCLES);
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_KERNEL_SIZE, 64'd1);
    write_reg(CFG_IN_WIDTH, 64'd2047);
    write_reg(CFG_OUT_WIDTH, 64'd2047);
    write_reg(CFG_OUT_HEIGHT, 64'd1);
    write_reg(CFG_COEFF_0, {$urandom, $urandom});
    for (int i = 0; i < MAX_LINE; i++) send_pixel(rand_pixel(), i == 0, ROW_PIX, '0);

    pause_until_drained(DRAIN_CYCLES);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/cv2_pkg.sv
rtl/core/cv2_cfg.sv
rtl/core/cv2_lmem.sv
rtl/core/cv2_mac.sv
rtl/core/cv2_ofifo.sv
rtl/core/conv2d_valid_byte_wrap.sv
sim/tb_top.sv
